### sv/ssca_pkg.sv
// Shared types, codes and constants of the slab size-class allocator.
`timescale 1ns / 1ps

package ssca_pkg;

  // Field widths
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned FILE_W     = 16;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned ITEM_W     = 18;
  localparam int unsigned ENTRY_W    = FILE_W + INDEX_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned MAX_CLASSES = 4;

  // Record header: three two-byte words
  localparam logic [ITEM_W-1:0] HDR_BYTES = ITEM_W'(3 * 2);

  // Register reset values
  localparam logic [SIZE_W-1:0]  RST_CLASS_A = SIZE_W'(64);
  localparam logic [SIZE_W-1:0]  RST_CLASS_B = SIZE_W'(256);
  localparam logic [SIZE_W-1:0]  RST_CLASS_C = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0]  RST_CLASS_D = SIZE_W'(4096);
  localparam logic [INDEX_W-1:0] RST_SPF     = INDEX_W'(1024);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPF     = 3'd4;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_CLASS  = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // input beat taken: match class, read free list heads
    logic commit;  // apply update and load the output register
  } ssca_cmd_t;

endpackage

### sv/ssca_ctrl.sv
// Control state machine of the slab size-class allocator.
`timescale 1ns / 1ps

module ssca_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output ssca_pkg::ssca_cmd_t cmd_o
);
  import ssca_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign s_ready_o     = (state_q == S_IDLE);
  assign m_valid_o     = out_valid_q;
  // Output register can take a result when empty or draining this cycle
  assign out_free      = !out_valid_q || m_ready_i;
  assign cmd_o.accept  = s_valid_i && (state_q == S_IDLE);
  assign cmd_o.commit  = (state_q == S_EXEC) && out_free;

  // Advance state and track the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_valid_i) begin
            state_q <= S_EXEC;
          end
          if (m_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/ssca_dp.sv
// Datapath of the slab size-class allocator: registers, free lists, file counters.
`timescale 1ns / 1ps

module ssca_dp #(
  parameter int unsigned NUM_CLASSES = 4,
  parameter int unsigned FREE_DEPTH  = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ssca_pkg::ssca_cmd_t                  cmd_i,
  input  logic                                 in_cmd_i,
  input  logic [ssca_pkg::IN_TDATA_W-1:0]      in_data_i,
  input  logic                                 cfg_we_i,
  input  logic [ssca_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ssca_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic [ssca_pkg::OUT_TDATA_W-1:0]     out_data_o
);
  import ssca_pkg::*;

  localparam int unsigned ACTIVE = (NUM_CLASSES < MAX_CLASSES) ? NUM_CLASSES : MAX_CLASSES;
  localparam int unsigned PW     = $clog2(FREE_DEPTH);
  localparam int unsigned CNTW   = $clog2(FREE_DEPTH + 1);
  localparam logic [PW-1:0]   LAST_PTR = PW'(FREE_DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(FREE_DEPTH);

  // Configuration registers
  logic [SIZE_W-1:0]  class_size_q [MAX_CLASSES];
  logic [INDEX_W-1:0] spf_q;

  // Per-class control state
  logic [PW-1:0]      head_q      [ACTIVE];
  logic [CNTW-1:0]    count_q     [ACTIVE];
  logic [INDEX_W-1:0] open_slot_q [ACTIVE];
  logic [FILE_W-1:0]  open_file_q [ACTIVE];
  logic [ACTIVE-1:0]  open_vld_q;
  logic [FILE_W-1:0]  next_file_q;
  logic [ENTRY_W-1:0] rd_q        [ACTIVE];
  logic [ACTIVE-1:0]  wr_en;

  // Latched command
  logic               cmd_q;
  logic [ACTIVE-1:0]  sel_q;
  logic [FILE_W-1:0]  fr_file_q;
  logic [INDEX_W-1:0] fr_index_q;
  logic [OUT_TDATA_W-1:0] out_q;

  // Input fields
  logic [LEN_W-1:0]   key_len;
  logic [LEN_W-1:0]   val_len;
  logic [SIZE_W-1:0]  fr_size;
  logic [ITEM_W-1:0]  need_bytes;
  logic [ACTIVE-1:0]  hit;
  logic [ACTIVE-1:0]  sel_d;

  assign key_len    = in_data_i[15:0];
  assign val_len    = in_data_i[31:16];
  assign fr_size    = in_data_i[48:32];
  assign need_bytes = ITEM_W'(key_len) + ITEM_W'(val_len) + HDR_BYTES;

  // Match classes and keep the first hit in register order
  always_comb begin
    logic found;
    found = 1'b0;
    sel_d = '0;
    for (int c = 0; c < ACTIVE; c++) begin
      if (in_cmd_i == CMD_ALLOC) begin
        hit[c] = ({1'b0, class_size_q[c]} >= need_bytes);
      end else begin
        hit[c] = (class_size_q[c] == fr_size);
      end
      if (hit[c] && !found) begin
        sel_d[c] = 1'b1;
        found    = 1'b1;
      end
    end
  end

  // Hold the command for the update cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q      <= in_cmd_i;
      sel_q      <= sel_d;
      fr_file_q  <= in_data_i[64:49];
      fr_index_q <= in_data_i[80:65];
    end
  end

  // Select the state of the matched class
  logic [SIZE_W-1:0]  s_size;
  logic [CNTW-1:0]    s_cnt;
  logic [ENTRY_W-1:0] s_rd;
  logic               s_vld;
  logic [INDEX_W-1:0] s_oslot;
  logic [FILE_W-1:0]  s_ofile;
  logic               found_any;

  always_comb begin
    s_size  = '0;
    s_cnt   = '0;
    s_rd    = '0;
    s_vld   = 1'b0;
    s_oslot = '0;
    s_ofile = '0;
    for (int c = 0; c < ACTIVE; c++) begin
      if (sel_q[c]) begin
        s_size  = class_size_q[c];
        s_cnt   = count_q[c];
        s_rd    = rd_q[c];
        s_vld   = open_vld_q[c];
        s_oslot = open_slot_q[c];
        s_ofile = open_file_q[c];
      end
    end
  end

  assign found_any = |sel_q;

  // Work out the result
  logic               need_open;
  logic               pop;
  logic [INDEX_W-1:0] bump_slot;
  logic [FILE_W-1:0]  bump_file;
  status_e            r_status;
  logic [SIZE_W-1:0]  r_size;
  logic [FILE_W-1:0]  r_file;
  logic [INDEX_W-1:0] r_index;
  logic               r_opened;

  assign need_open = !s_vld || (s_oslot >= spf_q);
  assign pop       = (s_cnt != '0);
  assign bump_slot = need_open ? '0 : s_oslot;
  assign bump_file = need_open ? next_file_q : s_ofile;

  always_comb begin
    r_status = ST_OK;
    r_size   = '0;
    r_file   = '0;
    r_index  = '0;
    r_opened = 1'b0;
    priority if (cmd_q == CMD_ALLOC) begin
      if (!found_any) begin
        r_status = ST_TOO_LARGE;
      end else if (pop) begin
        r_size  = s_size;
        r_file  = s_rd[ENTRY_W-1:INDEX_W];
        r_index = s_rd[INDEX_W-1:0];
      end else begin
        r_size   = s_size;
        r_file   = bump_file;
        r_index  = bump_slot;
        r_opened = need_open;
      end
    end else begin
      if (!found_any) begin
        r_status = ST_NO_CLASS;
      end else if (s_cnt == FULL_CNT) begin
        r_status = ST_LIST_FULL;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= {4'b0, r_opened, r_index, r_file, r_size, r_status};
    end
  end

  assign out_data_o = out_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_size_q[0] <= RST_CLASS_A;
      class_size_q[1] <= RST_CLASS_B;
      class_size_q[2] <= RST_CLASS_C;
      class_size_q[3] <= RST_CLASS_D;
      spf_q           <= RST_SPF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CLASS_A: class_size_q[0] <= cfg_data_i;
        REG_CLASS_B: class_size_q[1] <= cfg_data_i;
        REG_CLASS_C: class_size_q[2] <= cfg_data_i;
        REG_CLASS_D: class_size_q[3] <= cfg_data_i;
        REG_SPF:     spf_q           <= cfg_data_i[INDEX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Update free list pointers and open files of the matched class
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < ACTIVE; c++) begin
        head_q[c]      <= '0;
        count_q[c]     <= '0;
        open_slot_q[c] <= '0;
        open_file_q[c] <= '0;
      end
      open_vld_q  <= '0;
      next_file_q <= '0;
    end else if (cmd_i.commit) begin
      for (int c = 0; c < ACTIVE; c++) begin
        if (sel_q[c]) begin
          if (cmd_q == CMD_ALLOC) begin
            if (pop) begin
              head_q[c]  <= (head_q[c] == LAST_PTR) ? '0 : head_q[c] + 1'b1;
              count_q[c] <= count_q[c] - 1'b1;
            end else begin
              open_slot_q[c] <= bump_slot + 1'b1;
              open_file_q[c] <= bump_file;
              open_vld_q[c]  <= 1'b1;
            end
          end else if (wr_en[c]) begin
            count_q[c] <= count_q[c] + 1'b1;
          end
        end
      end
      if ((cmd_q == CMD_ALLOC) && found_any && !pop && need_open) begin
        next_file_q <= next_file_q + 1'b1;
      end
    end
  end

  // One free list memory per class: push at the tail, read the head on accept
  for (genvar g = 0; g < ACTIVE; g++) begin : g_list
    logic [ENTRY_W-1:0] mem [FREE_DEPTH];
    logic [PW:0]        tail_sum;
    logic [PW-1:0]      tail;

    assign tail_sum = {1'b0, head_q[g]} + (PW + 1)'(count_q[g]);
    assign tail     = (tail_sum >= (PW + 1)'(FREE_DEPTH)) ?
                      PW'(tail_sum - (PW + 1)'(FREE_DEPTH)) : tail_sum[PW-1:0];
    assign wr_en[g] = cmd_i.commit && (cmd_q == CMD_FREE) && sel_q[g] &&
                      (count_q[g] != FULL_CNT);

    always_ff @(posedge clk_i) begin
      if (wr_en[g]) begin
        mem[tail] <= {fr_file_q, fr_index_q};
      end
      if (cmd_i.accept) begin
        rd_q[g] <= mem[head_q[g]];
      end
    end
  end

endmodule

### sv/slab_size_class_allocator.sv
// Top level of the slab size-class allocator.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tuser command, tdata lengths and freed slot
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata status and allocated slot
//   cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each command has two phases: an accept cycle that matches the size class and
// reads the head of each class free list memory, then an update cycle that writes
// back pointers, counters and the free list and loads the output register.
// The update cycle waits while the output register holds a beat not yet taken.
// No input beat is taken during the update cycle.
// Reset clears all control state at once; no clearing pass follows.
`timescale 1ns / 1ps

module slab_size_class_allocator #(
  parameter int unsigned NUM_CLASSES = 4,
  parameter int unsigned FREE_DEPTH  = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] key_length, [31:16] value_length, [48:32] freed_slot_size,
  // [64:49] freed_file, [80:65] freed_index, [87:81] zero
  input  logic [ssca_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] command
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [1:0] status, [18:2] slot_size, [34:19] slot_file, [50:35] slot_index,
  // [51] opened_file, [55:52] zero
  output logic [ssca_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ssca_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ssca_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ssca_pkg::*;

  ssca_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  ssca_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd)
  );

  ssca_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .FREE_DEPTH  (FREE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### sv/ssca_checker.sv
// Port-level checks of the slab size-class allocator, bound to the top level.
`timescale 1ns / 1ps

module ssca_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [ssca_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import ssca_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // One command in flight: no beat taken in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken during update cycle");

  // Error results carry no slot
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[55:2] == '0))
    else $error("error result carries slot fields");

  // A freshly opened file hands out its first slot
  a_open_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[51] |-> (m_axis_tdata[50:35] == '0) &&
    (m_axis_tdata[1:0] == ST_OK))
    else $error("opened file did not start at slot zero");

endmodule

bind slab_size_class_allocator ssca_checker u_ssca_checker (.*);
